// File: sv/spcc_pkg.sv
package spcc_pkg;

    localparam int MAX_ATOMS_DEF     = 1024;
    localparam int MOLECULE_BITS_DEF = 8;
    localparam int PROBE_COUNT       = 14;
    localparam int COORD_W           = 20;
    localparam int PROBE_W           = COORD_W + 1;
    localparam int DIFF_W            = COORD_W + 3;
    localparam int SQ_W              = 2 * DIFF_W;
    localparam int SUM_W             = SQ_W + 2;
    localparam int DRAIN_CYCLES      = PROBE_COUNT + 6;
    localparam int DRAIN_W           = $clog2(DRAIN_CYCLES + 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_ATOM_COUNT = 3'd0;
    localparam logic [2:0] REG_BOX_LENGTH = 3'd1;
    localparam logic [2:0] REG_RADIUS_SQ  = 3'd2;
    localparam logic [2:0] REG_AXIS_OFF   = 3'd3;
    localparam logic [2:0] REG_DIAG_OFF   = 3'd4;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Sign of each probe offset per axis: six axis probes, then eight corners.
    localparam int PROBE_SX [PROBE_COUNT] = '{1, -1, 0, 0, 0, 0, 1, 1, 1, 1, -1, -1, -1, -1};
    localparam int PROBE_SY [PROBE_COUNT] = '{0, 0, 1, -1, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
    localparam int PROBE_SZ [PROBE_COUNT] = '{0, 0, 0, 0, 1, -1, 1, -1, 1, -1, 1, -1, 1, -1};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROBE_W-1:0] probe_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [10:0] atom_count;
        logic [18:0] box_length;
        logic [31:0] radius_sq;
        logic [11:0] axis_off;
        logic [11:0] diag_off;
    } cfg_t;

    typedef struct packed {
        logic        clear;
        logic        load_probe;
        coord_t      base_x;
        coord_t      base_y;
        coord_t      base_z;
        logic [11:0] axis_off;
        logic [11:0] diag_off;
        logic [18:0] box_length;
        logic [31:0] radius_sq;
    } cell_ctrl_t;

    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
        coord_t z;
    } atom_tok_t;

endpackage

// File: sv/spcc_ifs.sv
interface spcc_req_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic [9:0]          atom_index;
    logic signed [19:0]  pos_x;
    logic signed [19:0]  pos_y;
    logic signed [19:0]  pos_z;
    logic [7:0]          molecule;

    modport source (output valid, func, atom_index, pos_x, pos_y, pos_z, molecule,
                    input ready);
    modport sink (input valid, func, atom_index, pos_x, pos_y, pos_z, molecule,
                  output ready);
endinterface

interface spcc_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] queried_atom;
    logic [3:0] contact_count;

    modport source (output valid, queried_atom, contact_count, input ready);
    modport sink (input valid, queried_atom, contact_count, output ready);
endinterface

// File: sv/solvent_probe_contact_counter_unit.sv
// Solvent probe contact counter. Load requests write one atom (position and
// molecule number) into the atom store; query requests place fourteen probe
// points around the named atom and return how many of them lie strictly
// within the probe radius of another atom of the same molecule, with
// distances taken under minimum-image wrap in a periodic box. A load gives
// no response. A query makes one store read for the queried atom, then one
// store read per searched atom (atom_count, capped at MAX_ATOMS) as the
// atoms stream through a row of fourteen probe cells, one atom per cycle,
// and then drains that row; it is held in its last state only while the
// previous response still waits to be taken. The sweep runs over the single
// read port of the atom store. Requests are taken one at a time; a finished
// response waits in an output register while the next request is accepted.
// There is no clearing pass; atoms must be loaded before they are queried
// or searched.
// Configuration registers sit at byte addresses 4*i.
module solvent_probe_contact_counter_unit #(
    parameter int MAX_ATOMS     = spcc_pkg::MAX_ATOMS_DEF,
    parameter int MOLECULE_BITS = spcc_pkg::MOLECULE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    spcc_req_if.sink      req,
    spcc_rsp_if.source    rsp
);
    localparam int AW  = $clog2(MAX_ATOMS);
    localparam int CW  = $clog2(MAX_ATOMS + 1);
    localparam int NP  = spcc_pkg::PROBE_COUNT;
    localparam int PW  = 3 * spcc_pkg::COORD_W;
    localparam int RW  = PW + MOLECULE_BITS;

    spcc_pkg::cfg_t        cfg;
    spcc_pkg::state_t      state_reg, state_next;
    spcc_pkg::cell_ctrl_t  ctrl;
    spcc_pkg::atom_tok_t   tok [NP + 1];
    logic [NP-1:0]         hits;

    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [RW-1:0]              ram_wdata, ram_rdata;
    logic [MOLECULE_BITS-1:0]   rd_mol;

    logic [9:0]                 idx_reg;
    logic [MOLECULE_BITS-1:0]   mol_reg;
    logic [CW-1:0]              n_reg, j_reg;
    logic [AW-1:0]              jq_reg;
    logic                       issue_reg, issue_next;
    logic                       skip_reg;
    logic [spcc_pkg::DRAIN_W-1:0] drain_reg;
    logic                       out_valid_reg;
    logic [9:0]                 out_atom_reg;
    logic [3:0]                 out_count_reg;
    logic [3:0]                 count;
    logic                       req_fire, idx_ok, last_j;
    logic [CW-1:0]              n_cap;

    spcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req.ready = (state_reg == spcc_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign idx_ok    = 32'(req.atom_index) < MAX_ATOMS;

    // Each store row is the packed position (x low) with the molecule on top.
    assign ram_we    = req_fire && req.func == spcc_pkg::FUNC_LOAD && idx_ok;
    assign ram_wdata = {MOLECULE_BITS'(req.molecule), req.pos_z, req.pos_y, req.pos_x};
    assign ram_raddr = (state_reg == spcc_pkg::ST_IDLE) ? AW'(req.atom_index) : AW'(j_reg);
    assign rd_mol    = ram_rdata[RW-1:PW];

    spcc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(req.atom_index)),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_cap  = (32'(cfg.atom_count) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(cfg.atom_count);
    assign last_j = (32'(j_reg) + 1) == 32'(n_reg);

    // Broadcast control for the probe cells. The queried atom's entry is on
    // the read port during the cycle after the query is taken.
    always_comb
    begin
        ctrl.clear      = (state_reg == spcc_pkg::ST_BASE);
        ctrl.load_probe = (state_reg == spcc_pkg::ST_BASE);
        ctrl.base_x     = ram_rdata[19:0];
        ctrl.base_y     = ram_rdata[39:20];
        ctrl.base_z     = ram_rdata[59:40];
        ctrl.axis_off   = cfg.axis_off;
        ctrl.diag_off   = cfg.diag_off;
        ctrl.box_length = cfg.box_length;
        ctrl.radius_sq  = cfg.radius_sq;
    end

    // An atom enters the row only if it is another atom of the same molecule.
    assign tok[0] = {issue_reg && (32'(jq_reg) != 32'(idx_reg)) && (rd_mol == mol_reg),
                     ram_rdata[19:0], ram_rdata[39:20], ram_rdata[59:40]};

    for (genvar k = 0; k < NP; k++)
    begin : g_cell
        spcc_cell #(
            .SX   (spcc_pkg::PROBE_SX[k]),
            .SY   (spcc_pkg::PROBE_SY[k]),
            .SZ   (spcc_pkg::PROBE_SZ[k]),
            .DIAG (k >= 6)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .tok_in  (tok[k]),
            .tok_out (tok[k + 1]),
            .hit     (hits[k])
        );
    end

    always_comb
    begin
        count = 4'd0;
        for (int k = 0; k < NP; k++)
        begin
            count = count + 4'(hits[k]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue_next = 1'b0;
        unique case (state_reg)
            spcc_pkg::ST_IDLE:
            begin
                if (req_fire && req.func == spcc_pkg::FUNC_QUERY)
                    state_next = idx_ok ? spcc_pkg::ST_BASE : spcc_pkg::ST_DONE;
            end
            spcc_pkg::ST_BASE:
            begin
                state_next = (n_cap == '0) ? spcc_pkg::ST_DRAIN : spcc_pkg::ST_SWEEP;
            end
            spcc_pkg::ST_SWEEP:
            begin
                issue_next = 1'b1;
                if (last_j)
                    state_next = spcc_pkg::ST_DRAIN;
            end
            spcc_pkg::ST_DRAIN:
            begin
                if (drain_reg == spcc_pkg::DRAIN_W'(spcc_pkg::DRAIN_CYCLES))
                    state_next = spcc_pkg::ST_DONE;
            end
            spcc_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                    state_next = spcc_pkg::ST_IDLE;
            end
            default: state_next = spcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spcc_pkg::ST_IDLE;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            drain_reg     <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            if (state_reg == spcc_pkg::ST_SWEEP)
                j_reg <= j_reg + CW'(1);
            else
                j_reg <= '0;
            if (state_reg == spcc_pkg::ST_DRAIN)
                drain_reg <= drain_reg + spcc_pkg::DRAIN_W'(1);
            else
                drain_reg <= '0;
            if (state_reg == spcc_pkg::ST_DONE && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            idx_reg  <= req.atom_index;
            skip_reg <= !idx_ok;
        end
        if (state_reg == spcc_pkg::ST_BASE)
        begin
            mol_reg <= rd_mol;
            n_reg   <= n_cap;
        end
        jq_reg <= AW'(j_reg);
        if (state_reg == spcc_pkg::ST_DONE && !out_valid_reg)
        begin
            out_atom_reg  <= idx_reg;
            out_count_reg <= skip_reg ? 4'd0 : count;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.queried_atom  = out_atom_reg;
    assign rsp.contact_count = out_count_reg;

`ifndef SYNTHESIS
    a_done_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spcc_pkg::ST_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished query did not post a response");
    a_no_stream_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spcc_pkg::ST_IDLE && $past(state_reg) == spcc_pkg::ST_IDLE)
        |-> !issue_reg)
        else $error("store sweep active while idle");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg <= 4'd14)
        else $error("contact count above probe total");
`endif
endmodule

// File: sv/spcc_ram.sv
module spcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/spcc_regs.sv
module spcc_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output spcc_pkg::cfg_t    cfg
);
    spcc_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.atom_count <= 11'd1;
            cfg_reg.box_length <= 19'd76800;
            cfg_reg.radius_sq  <= 32'd802816;
            cfg_reg.axis_off   <= 12'd1536;
            cfg_reg.diag_off   <= 12'd887;
        end
        else if (wr_en)
        begin
            unique case (idx)
                spcc_pkg::REG_ATOM_COUNT: cfg_reg.atom_count <= pwdata[10:0];
                spcc_pkg::REG_BOX_LENGTH: cfg_reg.box_length <= pwdata[18:0];
                spcc_pkg::REG_RADIUS_SQ:  cfg_reg.radius_sq  <= pwdata;
                spcc_pkg::REG_AXIS_OFF:   cfg_reg.axis_off   <= pwdata[11:0];
                spcc_pkg::REG_DIAG_OFF:   cfg_reg.diag_off   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            spcc_pkg::REG_ATOM_COUNT: prdata = {21'd0, cfg_reg.atom_count};
            spcc_pkg::REG_BOX_LENGTH: prdata = {13'd0, cfg_reg.box_length};
            spcc_pkg::REG_RADIUS_SQ:  prdata = cfg_reg.radius_sq;
            spcc_pkg::REG_AXIS_OFF:   prdata = {20'd0, cfg_reg.axis_off};
            spcc_pkg::REG_DIAG_OFF:   prdata = {20'd0, cfg_reg.diag_off};
            default:                  prdata = 32'd0;
        endcase
    end
endmodule

// File: sv/spcc_cell.sv
module spcc_cell #(
    parameter int SX   = 0,
    parameter int SY   = 0,
    parameter int SZ   = 0,
    parameter bit DIAG = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spcc_pkg::cell_ctrl_t   ctrl,
    input  spcc_pkg::atom_tok_t    tok_in,
    output spcc_pkg::atom_tok_t    tok_out,
    output logic                   hit
);
    localparam int DW = spcc_pkg::DIFF_W;
    localparam int QW = spcc_pkg::SQ_W;
    localparam int UW = spcc_pkg::SUM_W;

    spcc_pkg::probe_t    px_reg, py_reg, pz_reg;
    logic                tok_valid_reg;
    spcc_pkg::coord_t    tok_x_reg, tok_y_reg, tok_z_reg;
    logic                a_valid_reg, b_valid_reg, hit_reg;
    logic [DW-1:0]       ax_reg, ay_reg, az_reg;
    logic [QW-1:0]       qx_reg, qy_reg, qz_reg;
    logic [11:0]         off;
    logic [UW-1:0]       sum;

    function automatic spcc_pkg::probe_t place(spcc_pkg::coord_t b, logic [11:0] o, int s);
        spcc_pkg::probe_t ob;
        ob = spcc_pkg::probe_t'({1'b0, o});
        if (s > 0)
            return spcc_pkg::probe_t'(b) + ob;
        else if (s < 0)
            return spcc_pkg::probe_t'(b) - ob;
        else
            return spcc_pkg::probe_t'(b);
    endfunction

    // Minimum-image difference, returned as a magnitude.
    function automatic logic [DW-1:0] wrap_mag(spcc_pkg::probe_t p, spcc_pkg::coord_t a,
                                               logic [18:0] box);
        logic signed [DW-1:0] d;
        logic signed [DW:0]   two_d;
        logic signed [DW:0]   boxs;
        d     = $signed(DW'(p)) - $signed(DW'(a));
        two_d = $signed({d, 1'b0});
        boxs  = $signed({{(DW + 1 - 19){1'b0}}, box});
        if (two_d > boxs)
            d = d - $signed({{(DW - 19){1'b0}}, box});
        else if (two_d < -boxs)
            d = d + $signed({{(DW - 19){1'b0}}, box});
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    assign off     = DIAG ? ctrl.diag_off : ctrl.axis_off;
    assign tok_out = {tok_valid_reg, tok_x_reg, tok_y_reg, tok_z_reg};
    assign hit     = hit_reg;
    assign sum     = UW'(qx_reg) + UW'(qy_reg) + UW'(qz_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_probe)
        begin
            px_reg <= place(ctrl.base_x, off, SX);
            py_reg <= place(ctrl.base_y, off, SY);
            pz_reg <= place(ctrl.base_z, off, SZ);
        end
        tok_x_reg <= tok_in.x;
        tok_y_reg <= tok_in.y;
        tok_z_reg <= tok_in.z;
        ax_reg <= wrap_mag(px_reg, tok_in.x, ctrl.box_length);
        ay_reg <= wrap_mag(py_reg, tok_in.y, ctrl.box_length);
        az_reg <= wrap_mag(pz_reg, tok_in.z, ctrl.box_length);
        qx_reg <= QW'(ax_reg) * QW'(ax_reg);
        qy_reg <= QW'(ay_reg) * QW'(ay_reg);
        qz_reg <= QW'(az_reg) * QW'(az_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
            a_valid_reg   <= tok_in.valid;
            b_valid_reg   <= a_valid_reg;
            if (ctrl.clear)
                hit_reg <= 1'b0;
            else if (b_valid_reg && sum < UW'(ctrl.radius_sq))
                hit_reg <= 1'b1;
        end
    end
endmodule
